/* rtl/rlh_pkg.sv */
// shared constants and types for the running lcm hyperperiod block
package rlh_pkg;

  localparam int PERIOD_BITS  = 32;
  localparam int IN_BITS      = 32;
  localparam int HP_BITS      = 63;
  localparam int DIV_CNT_BITS = $clog2(HP_BITS);
  localparam int MUL_CNT_BITS = $clog2(PERIOD_BITS);
  localparam int GCD_K_BITS   = $clog2(PERIOD_BITS);

  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [HP_BITS-1:0]     multiple_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOD,
    ST_GCD,
    ST_QUO,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

/* rtl/rlh_if.sv */
// valid/ready channel interfaces for task periods and hyperperiod results
interface rlh_in_if;
  import rlh_pkg::*;

  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] period;
  logic               last_task;

  modport source (output valid, output period, output last_task, input ready);
  modport sink   (input valid, input period, input last_task, output ready);
endinterface

interface rlh_out_if;
  import rlh_pkg::*;

  logic               valid;
  logic               ready;
  logic [HP_BITS-1:0] hyperperiod;
  logic               overflow;

  modport source (output valid, output hyperperiod, output overflow, input ready);
  modport sink   (input valid, input hyperperiod, input overflow, output ready);
endinterface

/* rtl/rlh_div.sv */
// restoring divider, one quotient bit per cycle, shared for mod and quotient
module rlh_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rlh_pkg::multiple_t dividend,
  input  rlh_pkg::period_t   divisor,
  output logic               done,
  output rlh_pkg::multiple_t quotient,
  output rlh_pkg::period_t   remainder
);
  import rlh_pkg::*;

  multiple_t               shreg;
  period_t                 rem;
  period_t                 dvs;
  logic [DIV_CNT_BITS-1:0] count;
  logic                    busy;
  logic [PERIOD_BITS:0]    trial;
  logic [PERIOD_BITS:0]    diff;
  logic                    fits;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    trial = {rem, shreg[HP_BITS-1]};
    fits  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
        count <= DIV_CNT_BITS'(HP_BITS - 1);
      end else if (busy) begin
        shreg <= {shreg[HP_BITS-2:0], fits};
        rem   <= fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = shreg;
  assign remainder = rem;

endmodule

/* rtl/rlh_gcd.sv */
// binary gcd, one shift or subtract-and-shift per cycle
module rlh_gcd (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rlh_pkg::period_t a,
  input  rlh_pkg::period_t b,
  output logic             done,
  output rlh_pkg::period_t g
);
  import rlh_pkg::*;

  period_t               u;
  period_t               v;
  logic [GCD_K_BITS-1:0] k;
  logic                  busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        u    <= a;
        v    <= b;
        k    <= '0;
      end else if (busy) begin
        if (u == '0 || v == '0) begin
          g    <= period_t'((u | v) << k);
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!u[0] && !v[0]) begin
          // common factor of two
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= (u - v) >> 1;
        end else begin
          v <= (v - u) >> 1;
        end
      end
    end
  end

endmodule

/* rtl/rlh_mul.sv */
// shift-add multiplier, one multiplier bit per cycle msb first, with overflow stop
module rlh_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rlh_pkg::multiple_t mcand,
  input  rlh_pkg::period_t   mplier,
  output logic               done,
  output logic               ovf,
  output rlh_pkg::multiple_t product
);
  import rlh_pkg::*;

  multiple_t               acc;
  multiple_t               mc;
  period_t                 mq;
  logic [MUL_CNT_BITS-1:0] count;
  logic                    busy;
  logic [HP_BITS+1:0]      sum;

  // acc only grows, so any carry past bit 62 means the final product is too big
  always_comb begin
    sum = {1'b0, acc, 1'b0} + (mq[PERIOD_BITS-1] ? {2'b00, mc} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        ovf   <= 1'b0;
        acc   <= '0;
        mc    <= mcand;
        mq    <= mplier;
        count <= MUL_CNT_BITS'(PERIOD_BITS - 1);
      end else if (busy) begin
        mq    <= mq << 1;
        count <= count - 1'b1;
        if (sum[HP_BITS+1:HP_BITS] != 2'b00) begin
          ovf  <= 1'b1;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          acc <= sum[HP_BITS-1:0];
          if (count == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign product = acc;

endmodule

/* rtl/running_lcm_hyperperiod.sv */
// top level: running lcm of task periods, hyperperiod per set
//
//  channel   dir  handshake      payload
//  periods   in   valid/ready    period[31:0], last_task
//  result    out  valid/ready    hyperperiod[62:0], overflow
//
// each word is accepted in ST_IDLE and checked in ST_CHECK; a first period, a zero
// period or a word after overflow then goes straight to ST_FIN
// otherwise: r mod p on the shared serial divider, binary gcd of p and the
// remainder, p/g on the same divider, shift-add multiply and the ST_FIN state;
// the divider's one-bit-per-cycle loop over the 63-bit running value sets the
// worst case per word
// synchronous reset clears the state, the running value, the overflow flag and
// the result valid flag; a held result does not stop the next word from being
// accepted, only the finish of a later last word waits for the result slot
module running_lcm_hyperperiod (
  input logic            clk,
  input logic            rst,
  rlh_in_if.sink         periods,
  rlh_out_if.source      result
);
  import rlh_pkg::*;

  state_t    state;
  state_t    state_next;

  // current word
  period_t   p_q;
  logic      last_q;

  // set state
  multiple_t running;
  multiple_t running_next;
  logic      ovf_seen;
  logic      ovf_seen_next;

  // result register
  logic      out_valid;
  multiple_t out_hp;
  logic      out_ovf;
  logic      out_load;

  // unit hookup
  logic      div_start;
  multiple_t div_dividend;
  period_t   div_divisor;
  logic      div_done;
  multiple_t div_quo;
  period_t   div_rem;

  logic      gcd_start;
  logic      gcd_done;
  period_t   gcd_g;

  logic      mul_start;
  logic      mul_done;
  logic      mul_ovf;
  multiple_t mul_prod;

  rlh_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rlh_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (p_q),
    .b     (div_rem),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rlh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (running),
    .mplier  (div_quo[PERIOD_BITS-1:0]),
    .done    (mul_done),
    .ovf     (mul_ovf),
    .product (mul_prod)
  );

  assign periods.ready = (state == ST_IDLE);

  // word capture, bits above PERIOD_BITS dropped
  always_ff @(posedge clk) begin
    if (periods.valid && periods.ready) begin
      p_q    <= PERIOD_BITS'(periods.period);
      last_q <= periods.last_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      running  <= '0;
      ovf_seen <= 1'b0;
    end else begin
      state    <= state_next;
      running  <= running_next;
      ovf_seen <= ovf_seen_next;
    end
  end

  always_comb begin
    state_next    = state;
    running_next  = running;
    ovf_seen_next = ovf_seen;
    div_start     = 1'b0;
    gcd_start     = 1'b0;
    mul_start     = 1'b0;
    out_load      = 1'b0;
    // second divider pass: p / gcd
    div_dividend  = multiple_t'(p_q);
    div_divisor   = gcd_g;
    case (state)
      ST_IDLE: begin
        if (periods.valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        div_dividend = running;
        div_divisor  = p_q;
        if (ovf_seen || p_q == '0) begin
          // word ignored
          state_next = ST_FIN;
        end else if (running == '0) begin
          // first usable period of the set
          running_next = multiple_t'(p_q);
          state_next   = ST_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (div_done) begin
          gcd_start  = 1'b1;
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          div_start  = 1'b1;
          state_next = ST_QUO;
        end
      end
      ST_QUO: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (mul_ovf) begin
            ovf_seen_next = 1'b1;
            running_next  = '0;
          end else begin
            running_next = mul_prod;
          end
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (!out_valid || result.ready) begin
          // hand off the hyperperiod and start a fresh set
          out_load      = 1'b1;
          running_next  = '0;
          ovf_seen_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result register, running is already zero after an overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hp  <= running;
      out_ovf <= ovf_seen;
    end
  end

  assign result.valid       = out_valid;
  assign result.hyperperiod = out_hp;
  assign result.overflow    = out_ovf;

endmodule

/* tb/sv/hyperperiod_checker.sv */
// checker: predicts the hyperperiod of each task set and compares the result words
module hyperperiod_checker (
  input  logic        clk,
  input  logic        rst,
  rlh_in_if           periods,
  rlh_out_if          result,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned sets_done,
  output int unsigned overflow_sets
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlh_pkg::*;

  localparam logic [63:0] LCM_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    multiple_t hyperperiod;
    logic      overflow;
  } hyper_t;

  hyper_t      hyper_due[$];
  logic [63:0] run_lcm;
  logic        ovf_seen;

  function automatic logic [63:0] euclid_gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 64'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // fold one period into the running multiple of the current set
  task automatic absorb_period(input logic [IN_BITS-1:0] raw);
    logic [63:0] p;
    logic [63:0] g;
    logic [63:0] q;
    p = 64'(raw) & ((64'd1 << PERIOD_BITS) - 64'd1);
    if (!ovf_seen && p != 64'd0) begin
      if (run_lcm == 64'd0) begin
        run_lcm = p;
      end else begin
        g = euclid_gcd64(run_lcm, p);
        q = run_lcm / g;
        if (q > LCM_CEIL / p) begin
          ovf_seen = 1'b1;
          run_lcm  = 64'd0;
        end else begin
          run_lcm = q * p;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    hyper_t want;
    hyper_t got;
    if (rst) begin
      hyper_due.delete();
      run_lcm       = 64'd0;
      ovf_seen      = 1'b0;
      mismatches    = 0;
      sets_done     = 0;
      overflow_sets = 0;
    end else begin
      // results first: a word leaving now belongs to a set closed earlier
      if (result.valid && result.ready) begin
        got.hyperperiod = result.hyperperiod;
        got.overflow    = result.overflow;
        if (hyper_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result hyperperiod=%0d overflow=%0b",
                     $realtime, got.hyperperiod, got.overflow);
        end else begin
          want = hyper_due.pop_front();
          if (got.hyperperiod !== want.hyperperiod || got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch hyperperiod exp=%0d got=%0d overflow exp=%0b got=%0b",
                       $realtime, want.hyperperiod, got.hyperperiod,
                       want.overflow, got.overflow);
          end
        end
      end
      if (periods.valid && periods.ready) begin
        absorb_period(periods.period);
        if (periods.last_task) begin
          want.overflow    = ovf_seen;
          want.hyperperiod = ovf_seen ? '0 : run_lcm[HP_BITS-1:0];
          hyper_due = {hyper_due, want};
          sets_done++;
          if (ovf_seen)
            overflow_sets++;
          run_lcm  = 64'd0;
          ovf_seen = 1'b0;
        end
      end
    end
    pending = hyper_due.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// testbench top: drives task periods and result back-pressure, gives the verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rlh_pkg::*;

  localparam int unsigned WORD_TARGET = 1750;
  localparam int unsigned HOLD_CYCLES = 3000;  // receiver hold-off under pressure
  localparam int unsigned TAIL_CYCLES = 300;   // above the slowest single word

  logic clk;
  logic rst;

  rlh_in_if  periods_ch ();
  rlh_out_if result_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sets_done;
  int unsigned overflow_sets;

  int unsigned words_sent;
  bit          sender_idles;   // sender may leave gaps between words
  bit          hold_armed;     // asks the receiver for one long hold-off

  running_lcm_hyperperiod dut (
    .clk    (clk),
    .rst    (rst),
    .periods(periods_ch),
    .result (result_ch)
  );

  hyperperiod_checker chk (
    .clk          (clk),
    .rst          (rst),
    .periods      (periods_ch),
    .result       (result_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .sets_done    (sets_done),
    .overflow_sets(overflow_sets)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one word and hold it until the block takes it; valid stays high
  // afterwards so back-to-back words never drop valid within a step
  task automatic send_word(input logic [IN_BITS-1:0] p, input bit last);
    if (sender_idles && $urandom_range(99) < 25) begin
      periods_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    periods_ch.valid     <= 1'b1;
    periods_ch.period    <= p;
    periods_ch.last_task <= last;
    do @(posedge clk); while (!periods_ch.ready);
    words_sent++;
  endtask

  // stop offering and wait until every predicted hyperperiod has been seen
  task automatic pause_until_drained();
    periods_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // one well-formed task set with random content; the families keep most
  // sets below overflow so the gcd/divide/multiply path runs many times
  task automatic send_random_set();
    int unsigned        n;
    int unsigned        kind;
    int unsigned        base;
    logic [IN_BITS-1:0] p;
    kind = $urandom_range(99);
    n    = (kind < 65) ? $urandom_range(2, 8) : $urandom_range(1, 5);
    base = $urandom_range(1, 5000);
    for (int unsigned i = 0; i < n; i++) begin
      if (kind < 45)
        p = base * $urandom_range(1, 12);        // harmonic periods, modest lcm
      else if (kind < 65)
        p = $urandom_range(1, 60);               // small coprime-ish periods
      else if (kind < 85)
        p = $urandom();                          // full width, overflow likely
      else begin
        case ($urandom_range(4))                 // noise: zeros, ones, 2^k, others
          0:       p = '0;
          1:       p = 1;
          2:       p = 32'd1 << $urandom_range(31);
          3:       p = $urandom();
          default: p = $urandom_range(1, 255);
        endcase
      end
      send_word(p, i == n - 1);
    end
  endtask

  // receiver: random stalls, a quiet window with ready held high, and one
  // long counted hold-off so the result slot fills and input stalls
  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_armed) begin
        hold_armed = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end else if (cyc >= 150000 && cyc < 200000)
        result_ch.ready <= 1'b1;
      else
        result_ch.ready <= ($urandom_range(99) >= 25);
    end
  end

  initial begin : stimulus
    rst                  = 1'b1;
    periods_ch.valid     = 1'b0;
    periods_ch.period    = '0;
    periods_ch.last_task = 1'b0;
    words_sent           = 0;
    sender_idles         = 1'b1;
    hold_armed           = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed sets
    send_word(32'd1, 1'b1);                      // single period of one
    send_word(32'd0, 1'b1);                      // zero period alone
    send_word(32'd0, 1'b0);                      // set with no usable period
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b1);
    send_word(32'd0, 1'b0);                      // zeros around a one
    send_word(32'd1, 1'b0);
    send_word(32'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);              // largest period alone
    send_word(32'd4, 1'b0);                      // textbook lcm of 60
    send_word(32'd6, 1'b0);
    send_word(32'd10, 1'b1);
    send_word(32'h8000_0000, 1'b0);              // gcd is the smaller period
    send_word(32'h4000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);              // coprime, just below the ceiling
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b0);              // near the ceiling, divisors keep it,
    send_word(32'hFFFF_FFFF, 1'b0);              // then a factor of seven overflows
    send_word(32'd3, 1'b0);
    send_word(32'd7, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);              // overflow on the second period,
    send_word(32'hFFFF_FFFE, 1'b0);              // later periods ignored
    send_word(32'd0, 1'b0);
    send_word(32'd5, 1'b1);
    send_word(32'd12, 1'b0);                     // repeated period after a clear
    send_word(32'd12, 1'b1);

    // pressure: receiver holds off while short sets keep coming
    sender_idles = 1'b0;
    hold_armed   = 1'b1;
    repeat (40) send_word($urandom_range(1, 1000), 1'b1);
    pause_until_drained();
    sender_idles = 1'b1;

    // random sets, with a gap-free stretch and drain pauses midway
    while (words_sent < WORD_TARGET) begin
      sender_idles = !(words_sent >= 700 && words_sent < 1000);
      if (words_sent >= 1200 && words_sent < 1210)
        pause_until_drained();
      send_random_set();
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words in %0d task sets, %0d sets overflowed",
             words_sent, sets_done, overflow_sets);
    $display("zero, unit, power-of-two and full-width periods; long result hold-off");
    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // hard limit, many times the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
rtl/rlh_pkg.sv
rtl/rlh_if.sv
rtl/rlh_div.sv
rtl/rlh_gcd.sv
rtl/rlh_mul.sv
rtl/running_lcm_hyperperiod.sv
tb/sv/hyperperiod_checker.sv
tb/sv/tb_top.sv
